[src/rpf_pkg.sv]
// Shared types, codes and the CRC-16 byte update for the radio packet framer.
// No dependencies; used by every module of the framer.
package rpf_pkg;

  // Command codes carried on the input selector
  localparam logic [2:0] CMD_TX_START = 3'd0;
  localparam logic [2:0] CMD_TX_BYTE  = 3'd1;
  localparam logic [2:0] CMD_LISTEN   = 3'd2;
  localparam logic [2:0] CMD_RX_BYTE  = 3'd3;
  localparam logic [2:0] CMD_RELEASE  = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_TX_LINE    = 2'd0;
  localparam logic [1:0] KIND_RX_BYTE    = 2'd1;
  localparam logic [1:0] KIND_RX_VERDICT = 2'd2;
  localparam logic [1:0] KIND_CMD        = 2'd3;

  // Verdict status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_CRC_BAD = 2'd2;
  localparam logic [1:0] ST_LEN_BAD = 2'd3;

  // Config register indexes
  localparam logic REG_NODE_ID  = 1'b0;
  localparam logic REG_GROUP_ID = 1'b1;

  // Line constants
  localparam logic [7:0]  PREAMBLE  = 8'hAA;
  localparam logic [7:0]  SYNC_BYTE = 8'h2D;
  localparam logic [7:0]  TAIL_LO   = 8'h10;
  localparam logic [7:0]  TAIL_HI   = 8'h20;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SEND,
    MODE_RECV,
    MODE_HELD
  } mode_t;

  typedef enum logic [1:0] {
    JOB_VERDICT,
    JOB_TX_HDR,
    JOB_TX_BYTE,
    JOB_RX_BYTE
  } job_op_t;

  // One classified item handed from front to back
  typedef struct packed {
    job_op_t    op;
    logic [7:0] data;   // payload byte, rx byte or payload length
    logic [7:0] group;
    logic [7:0] node;
    logic       extra;  // trailer follows (tx) or frame verdict follows (rx)
    logic [1:0] vstat;  // verdict status
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Reflected CRC-16, one byte
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[src/rpf_front.sv]
// Front end of the framer: takes each command, keeps mode, rx CRC and counts,
// and emits one job descriptor per item. Depends on rpf_pkg.
module rpf_front #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [2:0]    cmd,
  input  logic [7:0]    data,
  input  logic [6:0]    payload_len,
  input  logic          channel_busy,
  input  logic [7:0]    node_id,
  input  logic [7:0]    group_id,
  output logic          push,
  output rpf_pkg::job_t job
);

  localparam logic [7:0] MAX_LEN   = 8'(MAX_PAYLOAD);
  localparam logic [7:0] RX_LIMIT  = 8'(MAX_PAYLOAD + 12);

  rpf_pkg::mode_t mode, mode_next;
  logic [15:0]    crc, crc_next;
  logic [7:0]     byte_count, byte_count_next;
  logic [7:0]     frame_length, frame_length_next;

  logic [15:0] crc_seed, crc_rx;
  logic [7:0]  bc_inc, fl_rx;
  logic        rx_end, tx_done, plen_bad, tx_ok;
  logic [1:0]  rx_stat;

  assign crc_seed = rpf_pkg::crc_feed(rpf_pkg::CRC_INIT, group_id);
  assign crc_rx   = rpf_pkg::crc_feed(crc, data);
  assign bc_inc   = byte_count + 8'd1;
  assign fl_rx    = (byte_count == 8'd1) ? data : frame_length;
  assign rx_end   = ((bc_inc >= 8'd2) && ({1'b0, bc_inc} >= ({1'b0, fl_rx} + 9'd4)))
                    || (bc_inc >= RX_LIMIT);
  assign tx_done  = bc_inc >= frame_length;
  assign plen_bad = {1'b0, payload_len} > MAX_LEN;
  assign tx_ok    = (mode == rpf_pkg::MODE_IDLE) && !channel_busy;

  always_comb begin
    if ((bc_inc < 8'd2) || (fl_rx > MAX_LEN)) begin
      rx_stat = rpf_pkg::ST_LEN_BAD;
    end else if (crc_rx != 16'h0000) begin
      rx_stat = rpf_pkg::ST_CRC_BAD;
    end else begin
      rx_stat = rpf_pkg::ST_OK;
    end
  end

  // next state
  always_comb begin
    mode_next         = mode;
    crc_next          = crc;
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    if (accept) begin
      unique case (cmd)
        rpf_pkg::CMD_TX_START: begin
          if (tx_ok && !plen_bad) begin
            byte_count_next   = 8'd0;
            frame_length_next = {1'b0, payload_len};
            mode_next = (payload_len == 7'd0) ? rpf_pkg::MODE_IDLE : rpf_pkg::MODE_SEND;
          end
        end
        rpf_pkg::CMD_TX_BYTE: begin
          if (mode == rpf_pkg::MODE_SEND) begin
            byte_count_next = bc_inc;
            if (tx_done) begin
              mode_next = rpf_pkg::MODE_IDLE;
            end
          end
        end
        rpf_pkg::CMD_LISTEN: begin
          if (mode == rpf_pkg::MODE_IDLE) begin
            mode_next         = rpf_pkg::MODE_RECV;
            crc_next          = crc_seed;
            byte_count_next   = 8'd0;
            frame_length_next = 8'd0;
          end
        end
        rpf_pkg::CMD_RX_BYTE: begin
          if (mode == rpf_pkg::MODE_RECV) begin
            crc_next          = crc_rx;
            frame_length_next = fl_rx;
            byte_count_next   = bc_inc;
            if (rx_end) begin
              if (rx_stat == rpf_pkg::ST_OK) begin
                mode_next = rpf_pkg::MODE_HELD;
              end else begin
                // bad frame: listen again from scratch
                crc_next          = crc_seed;
                byte_count_next   = 8'd0;
                frame_length_next = 8'd0;
              end
            end
          end
        end
        rpf_pkg::CMD_RELEASE: begin
          if (mode == rpf_pkg::MODE_HELD) begin
            mode_next = rpf_pkg::MODE_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // job descriptor
  always_comb begin
    push      = accept;
    job.op    = rpf_pkg::JOB_VERDICT;
    job.data  = data;
    job.group = group_id;
    job.node  = node_id;
    job.extra = 1'b0;
    job.vstat = rpf_pkg::ST_REJECT;
    unique case (cmd)
      rpf_pkg::CMD_TX_START: begin
        if (!tx_ok) begin
          job.vstat = rpf_pkg::ST_REJECT;
        end else if (plen_bad) begin
          job.vstat = rpf_pkg::ST_LEN_BAD;
        end else begin
          job.op    = rpf_pkg::JOB_TX_HDR;
          job.data  = {1'b0, payload_len};
          job.extra = (payload_len == 7'd0);
        end
      end
      rpf_pkg::CMD_TX_BYTE: begin
        if (mode == rpf_pkg::MODE_SEND) begin
          job.op    = rpf_pkg::JOB_TX_BYTE;
          job.extra = tx_done;
        end
      end
      rpf_pkg::CMD_LISTEN: begin
        if (mode == rpf_pkg::MODE_IDLE) begin
          job.vstat = rpf_pkg::ST_OK;
        end
      end
      rpf_pkg::CMD_RX_BYTE: begin
        if (mode == rpf_pkg::MODE_RECV) begin
          job.op    = rpf_pkg::JOB_RX_BYTE;
          job.extra = rx_end;
          job.vstat = rx_stat;
        end
      end
      rpf_pkg::CMD_RELEASE: begin
        if (mode == rpf_pkg::MODE_HELD) begin
          job.vstat = rpf_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= rpf_pkg::MODE_IDLE;
      crc          <= rpf_pkg::CRC_INIT;
      byte_count   <= 8'd0;
      frame_length <= 8'd0;
    end else begin
      mode         <= mode_next;
      crc          <= crc_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
    end
  end

endmodule

[src/rpf_fifo.sv]
// Short job queue between front and back of the framer.
// Depends on rpf_pkg for the job and status types.
module rpf_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rpf_pkg::job_t       wr_job,
  input  logic                pop,
  output rpf_pkg::job_t       rd_job,
  output rpf_pkg::fifo_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rpf_pkg::job_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign stat.full  = count == CW'(DEPTH);
  assign stat.empty = count == '0;
  assign rd_job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[src/rpf_back.sv]
// Back end of the framer: expands each job into result bytes, one per cycle
// unless m_* stalls; keeps the transmit CRC. Depends on rpf_pkg.
module rpf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  rpf_pkg::job_t job,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,
  output logic [1:0]    m_tuser,
  output logic          m_tlast
);

  rpf_pkg::job_t cur;
  logic          cur_valid;
  logic [3:0]    idx;
  logic [15:0]   crc;

  logic [7:0]  res_byte;
  logic [1:0]  res_kind, res_stat;
  logic        res_last, crc_load;
  logic [15:0] crc_base, crc_upd;
  logic        advance, emit, finish;

  always_comb begin
    res_byte = 8'h00;
    res_kind = rpf_pkg::KIND_TX_LINE;
    res_stat = rpf_pkg::ST_OK;
    res_last = 1'b1;
    crc_load = 1'b0;
    crc_base = crc;
    unique case (cur.op)
      rpf_pkg::JOB_VERDICT: begin
        res_kind = rpf_pkg::KIND_CMD;
        res_stat = cur.vstat;
      end
      rpf_pkg::JOB_TX_HDR: begin
        res_last = cur.extra ? (idx == 4'd10) : (idx == 4'd6);
        unique case (idx)
          4'd0, 4'd1, 4'd2: res_byte = rpf_pkg::PREAMBLE;
          4'd3: res_byte = rpf_pkg::SYNC_BYTE;
          4'd4: begin
            res_byte = cur.group;
            crc_load = 1'b1;
            crc_base = rpf_pkg::CRC_INIT;
          end
          4'd5: begin
            res_byte = cur.node;
            crc_load = 1'b1;
          end
          4'd6: begin
            res_byte = cur.data;
            crc_load = 1'b1;
          end
          4'd7:    res_byte = crc[7:0];
          4'd8:    res_byte = crc[15:8];
          4'd9:    res_byte = rpf_pkg::TAIL_LO;
          default: res_byte = rpf_pkg::TAIL_HI;
        endcase
      end
      rpf_pkg::JOB_TX_BYTE: begin
        res_last = cur.extra ? (idx == 4'd4) : (idx == 4'd0);
        unique case (idx)
          4'd0: begin
            res_byte = cur.data;
            crc_load = 1'b1;
          end
          4'd1:    res_byte = crc[7:0];
          4'd2:    res_byte = crc[15:8];
          4'd3:    res_byte = rpf_pkg::TAIL_LO;
          default: res_byte = rpf_pkg::TAIL_HI;
        endcase
      end
      rpf_pkg::JOB_RX_BYTE: begin
        res_last = cur.extra ? (idx == 4'd1) : (idx == 4'd0);
        if (idx == 4'd0) begin
          res_byte = cur.data;
          res_kind = rpf_pkg::KIND_RX_BYTE;
        end else begin
          res_kind = rpf_pkg::KIND_RX_VERDICT;
          res_stat = cur.vstat;
        end
      end
      default: begin
      end
    endcase
  end

  assign crc_upd = rpf_pkg::crc_feed(crc_base, res_byte);
  assign advance = !m_tvalid || m_tready;
  assign emit    = advance && cur_valid;
  assign finish  = emit && res_last;
  assign pop     = job_valid && (!cur_valid || finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 4'd0;
      crc       <= rpf_pkg::CRC_INIT;
      m_tvalid  <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (advance) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= 4'd0;
      end else if (finish) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        idx <= idx + 4'd1;
      end
      if (emit && crc_load) begin
        crc <= crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= job;
    end
    if (emit) begin
      m_tdata <= {6'd0, res_stat, res_byte};
      m_tuser <= res_kind;
      m_tlast <= res_last;
    end
  end

endmodule

[src/radio_packet_framer_crc16.sv]
// Top level of the radio packet framer/deframer with CRC-16 (poly 0xA001).
// Instantiates rpf_front, rpf_fifo and rpf_back; types from rpf_pkg.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tuser=cmd; tdata=data,payload_len,busy
//  m_*      | out | m_tvalid/m_tready  | tuser=kind; tdata=out_byte,status; tlast
//  cfg_*    | in  | cfg_valid/cfg_ready| cfg_index (0 node_id, 1 group_id), cfg_data
//
// The front takes one command per cycle while the job queue has room; each
// command becomes a single job in the queue. The back turns a job into 1 to
// 11 result transfers, one per cycle while m_tready holds. A command passes
// through the queue, the back's current job register and the output register.
// Synchronous reset clears mode, counts, CRCs, config, queue and output valid.
// A stall on m_* only backs up into the queue; s_tready drops once it is full.
module radio_packet_framer_crc16 #(
  parameter int MAX_PAYLOAD = 64,
  parameter int FIFO_DEPTH  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data, [14:8] payload_len, [15] channel_busy
  input  logic [2:0]  s_tuser,   // [2:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,   // last result caused by the command
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] node_id, group_id;
  logic       accept, push, pop;

  rpf_pkg::job_t       job_in, job_out;
  rpf_pkg::fifo_stat_t fstat;

  assign cfg_ready = 1'b1;
  assign s_tready  = !fstat.full;
  assign accept    = s_tvalid && s_tready;

  // config registers, writable in any cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id  <= 8'd0;
      group_id <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rpf_pkg::REG_NODE_ID:  node_id  <= cfg_data;
        rpf_pkg::REG_GROUP_ID: group_id <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rpf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (s_tuser),
    .data        (s_tdata[7:0]),
    .payload_len (s_tdata[14:8]),
    .channel_busy(s_tdata[15]),
    .node_id     (node_id),
    .group_id    (group_id),
    .push        (push),
    .job         (job_in)
  );

  rpf_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_job(job_in),
    .pop   (pop),
    .rd_job(job_out),
    .stat  (fstat)
  );

  rpf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(!fstat.empty),
    .job      (job_out),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // line and echo bytes never carry a status
  a_data_no_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == rpf_pkg::KIND_TX_LINE || m_tuser == rpf_pkg::KIND_RX_BYTE)
      |-> m_tdata[9:8] == 2'd0)
    else $error("status set on a data result");

  // verdicts carry a zero byte
  a_verdict_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == rpf_pkg::KIND_RX_VERDICT || m_tuser == rpf_pkg::KIND_CMD)
      |-> m_tdata[7:0] == 8'd0)
    else $error("nonzero byte on a verdict");

  // command and frame verdicts always close out their command
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == rpf_pkg::KIND_RX_VERDICT || m_tuser == rpf_pkg::KIND_CMD)
      |-> m_tlast)
    else $error("verdict not marked last");

  // queue can never be full and empty at once
  a_fifo_sane: assert property (@(posedge clk) disable iff (rst)
    !(fstat.full && fstat.empty))
    else $error("job queue full and empty");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for radio_packet_framer_crc16: directed and random traffic
// with a CRC-16 framer predictor in a small scoreboard class.
// Depends on rpf_pkg (codes, kinds, status, mode enum) and the framer top level.
module tb_top;

  localparam int PAYLOAD_MAX = 64;
  localparam int RX_BUF_LIMIT = PAYLOAD_MAX + 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEMS_PER_PHASE = 75;

  // cmd codes the block does not define; both must be refused
  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  // One result transfer as the m_* side should present it
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [1:0] status;
    logic       last;
  } line_result_t;

  // Predictor of the framer plus the queue of results it has promised.
  class framer_scoreboard;
    logic [7:0]      node;
    logic [7:0]      group;
    rpf_pkg::mode_t  mode;
    logic [15:0]     crc;
    logic [7:0]      count;
    logic [7:0]      flen;
    line_result_t    expected_results[$];
    int              errors;

    function new();
      node   = 8'h00;
      group  = 8'h00;
      mode   = rpf_pkg::MODE_IDLE;
      crc    = rpf_pkg::CRC_INIT;
      count  = 8'h00;
      flen   = 8'h00;
      errors = 0;
    endfunction

    // reflected CRC-16, poly 0xA001, one byte
    function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ rpf_pkg::CRC_POLY) : (r >> 1);
      end
      return r;
    endfunction

    function logic [15:0] crc_seed();
      return crc16_step(rpf_pkg::CRC_INIT, group);
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      if (idx == rpf_pkg::REG_NODE_ID) begin
        node = val;
      end else begin
        group = val;
      end
    endfunction

    function void push(logic [7:0] b, logic [1:0] k, logic [1:0] st);
      line_result_t r;
      r.out_byte = b;
      r.kind     = k;
      r.status   = st;
      r.last     = 1'b0;
      expected_results.push_back(r);
    endfunction

    function void push_trailer();
      push(crc[7:0], rpf_pkg::KIND_TX_LINE, rpf_pkg::ST_OK);
      push(crc[15:8], rpf_pkg::KIND_TX_LINE, rpf_pkg::ST_OK);
      push(rpf_pkg::TAIL_LO, rpf_pkg::KIND_TX_LINE, rpf_pkg::ST_OK);
      push(rpf_pkg::TAIL_HI, rpf_pkg::KIND_TX_LINE, rpf_pkg::ST_OK);
    endfunction

    function void restart_rx();
      mode  = rpf_pkg::MODE_RECV;
      crc   = crc_seed();
      count = 8'h00;
      flen  = 8'h00;
    endfunction

    // called once per accepted s_* transfer
    function void note_command(logic [2:0] cmd, logic [7:0] data, logic [6:0] plen,
                               logic busy);
      logic [1:0] st;
      unique case (cmd)
        rpf_pkg::CMD_TX_START: begin
          if (mode != rpf_pkg::MODE_IDLE || busy) begin
            push(8'h00, rpf_pkg::KIND_CMD, rpf_pkg::ST_REJECT);
          end else if (int'(plen) > PAYLOAD_MAX) begin
            push(8'h00, rpf_pkg::KIND_CMD, rpf_pkg::ST_LEN_BAD);
          end else begin
            push(rpf_pkg::PREAMBLE, rpf_pkg::KIND_TX_LINE, rpf_pkg::ST_OK);
            push(rpf_pkg::PREAMBLE, rpf_pkg::KIND_TX_LINE, rpf_pkg::ST_OK);
            push(rpf_pkg::PREAMBLE, rpf_pkg::KIND_TX_LINE, rpf_pkg::ST_OK);
            push(rpf_pkg::SYNC_BYTE, rpf_pkg::KIND_TX_LINE, rpf_pkg::ST_OK);
            push(group, rpf_pkg::KIND_TX_LINE, rpf_pkg::ST_OK);
            push(node, rpf_pkg::KIND_TX_LINE, rpf_pkg::ST_OK);
            push({1'b0, plen}, rpf_pkg::KIND_TX_LINE, rpf_pkg::ST_OK);
            crc   = crc16_step(crc16_step(crc_seed(), node), {1'b0, plen});
            count = 8'h00;
            flen  = {1'b0, plen};
            if (plen == 7'd0) begin
              push_trailer();
              mode = rpf_pkg::MODE_IDLE;
            end else begin
              mode = rpf_pkg::MODE_SEND;
            end
          end
        end
        rpf_pkg::CMD_TX_BYTE: begin
          if (mode != rpf_pkg::MODE_SEND) begin
            push(8'h00, rpf_pkg::KIND_CMD, rpf_pkg::ST_REJECT);
          end else begin
            push(data, rpf_pkg::KIND_TX_LINE, rpf_pkg::ST_OK);
            crc   = crc16_step(crc, data);
            count = count + 8'd1;
            if (count >= flen) begin
              push_trailer();
              mode = rpf_pkg::MODE_IDLE;
            end
          end
        end
        rpf_pkg::CMD_LISTEN: begin
          if (mode != rpf_pkg::MODE_IDLE) begin
            push(8'h00, rpf_pkg::KIND_CMD, rpf_pkg::ST_REJECT);
          end else begin
            restart_rx();
            push(8'h00, rpf_pkg::KIND_CMD, rpf_pkg::ST_OK);
          end
        end
        rpf_pkg::CMD_RX_BYTE: begin
          if (mode != rpf_pkg::MODE_RECV) begin
            push(8'h00, rpf_pkg::KIND_CMD, rpf_pkg::ST_REJECT);
          end else begin
            push(data, rpf_pkg::KIND_RX_BYTE, rpf_pkg::ST_OK);
            crc = crc16_step(crc, data);
            if (count == 8'd1) begin
              flen = data;
            end
            count = count + 8'd1;
            // frame ends after len+4 bytes or at the buffer limit
            if ((int'(count) >= 2 && int'(count) >= int'(flen) + 4) ||
                int'(count) >= RX_BUF_LIMIT) begin
              if (int'(count) < 2 || int'(flen) > PAYLOAD_MAX) begin
                st = rpf_pkg::ST_LEN_BAD;
              end else if (crc != 16'h0000) begin
                st = rpf_pkg::ST_CRC_BAD;
              end else begin
                st = rpf_pkg::ST_OK;
              end
              push(8'h00, rpf_pkg::KIND_RX_VERDICT, st);
              if (st == rpf_pkg::ST_OK) begin
                mode = rpf_pkg::MODE_HELD;
              end else begin
                restart_rx();
              end
            end
          end
        end
        rpf_pkg::CMD_RELEASE: begin
          if (mode != rpf_pkg::MODE_HELD) begin
            push(8'h00, rpf_pkg::KIND_CMD, rpf_pkg::ST_REJECT);
          end else begin
            mode = rpf_pkg::MODE_IDLE;
            push(8'h00, rpf_pkg::KIND_CMD, rpf_pkg::ST_OK);
          end
        end
        default: begin
          push(8'h00, rpf_pkg::KIND_CMD, rpf_pkg::ST_REJECT);
        end
      endcase
      // every command causes at least one result
      expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    // called once per accepted m_* transfer
    function void check_result(logic [7:0] b, logic [1:0] k, logic [1:0] st, logic lst,
                               logic [5:0] pad);
      line_result_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_byte %02h kind %0d status %0d last %0d",
               b, k, st, lst);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (b !== e.out_byte) begin
          $error("out_byte mismatch: expected %02h, actual %02h", e.out_byte, b);
          errors++;
        end
        if (k !== e.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", e.kind, k);
          errors++;
        end
        if (st !== e.status) begin
          $error("status mismatch: expected %0d, actual %0d", e.status, st);
          errors++;
        end
        if (lst !== e.last) begin
          $error("last mismatch: expected %0d, actual %0d", e.last, lst);
          errors++;
        end
        if (pad !== 6'd0) begin
          $error("tdata pad mismatch: expected 0, actual %02h", pad);
          errors++;
        end
      end
    endfunction
  endclass

  // DUT-facing signals; every input starts at a known value
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'h0000;  // [7:0] data, [14:8] payload_len, [15] channel_busy
  logic [2:0]  s_tuser = 3'd0;      // [2:0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;             // [7:0] out_byte, [9:8] status, [15:10] zero
  logic [1:0]  m_tuser;             // [1:0] kind
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'h00;

  framer_scoreboard sb = new();

  // idle / stall odds in percent, changed per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int phase_items = 0;
  int cycles = 0;

  radio_packet_framer_crc16 #(
    .MAX_PAYLOAD(PAYLOAD_MAX)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random backpressure at the phase's stall rate. With the rate at
  // zero tready just stays high.
  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Result monitor; values read here are the ones the block saw at this edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata[7:0], m_tuser, m_tdata[9:8], m_tlast, m_tdata[15:10]);
    end
  end

  // Watchdog: a hang or lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One s_* transfer. tvalid stays high across back-to-back transfers and is
  // only dropped for a random gap, so it never toggles within one time step.
  task automatic put_item(input logic [2:0] cmd, input logic [7:0] data,
                          input logic [6:0] plen, input logic busy);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {busy, plen, data};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_command(cmd, data, plen, busy);
    phase_items++;
  endtask

  // rx byte with junk in the fields the block should ignore
  task automatic rx_byte(input logic [7:0] b);
    put_item(rpf_pkg::CMD_RX_BYTE, b, 7'($urandom_range(127)), 1'($urandom_range(1)));
  endtask

  // One received frame: id, len, payload, CRC lo/hi. flip_at >= 0 corrupts
  // one bit of that byte.
  task automatic rx_frame(input int len, input int flip_at);
    logic [7:0]  fr[$];
    logic [15:0] c;
    c = sb.crc_seed();
    fr.push_back(8'($urandom));
    fr.push_back(8'(len));
    for (int i = 0; i < len; i++) fr.push_back(8'($urandom));
    foreach (fr[i]) c = sb.crc16_step(c, fr[i]);
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
    if (flip_at >= 0) begin
      fr[flip_at] = fr[flip_at] ^ (8'h01 << $urandom_range(7));
    end
    foreach (fr[i]) rx_byte(fr[i]);
  endtask

  // finish a partly received frame with random bytes until its verdict
  task automatic rx_flush();
    while (sb.mode == rpf_pkg::MODE_RECV && sb.count != 8'd0) rx_byte(8'($urandom));
  endtask

  // Steer the block back to idle by legal traffic only.
  task automatic go_idle();
    while (sb.mode != rpf_pkg::MODE_IDLE) begin
      unique case (sb.mode)
        rpf_pkg::MODE_SEND: begin
          put_item(rpf_pkg::CMD_TX_BYTE, 8'($urandom), 7'($urandom), 1'($urandom));
        end
        rpf_pkg::MODE_RECV: begin
          if (sb.count != 8'd0) begin
            rx_flush();
          end else begin
            rx_frame(0, -1);
          end
        end
        default: begin
          put_item(rpf_pkg::CMD_RELEASE, 8'($urandom), 7'($urandom), 1'($urandom));
        end
      endcase
    end
  endtask

  // Sender holds off until every promised result has been seen.
  task automatic wait_empty();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // Register write; the caller drops cfg_valid after the last one.
  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Reconfigure only with the block idle and the output drained; the extra
  // wait covers the path from front to back.
  task automatic set_regs(input logic [7:0] node_val, input logic [7:0] group_val);
    go_idle();
    wait_empty();
    repeat (8) @(posedge clk);
    write_reg(rpf_pkg::REG_NODE_ID, node_val);
    write_reg(rpf_pkg::REG_GROUP_ID, group_val);
    cfg_valid <= 1'b0;
  endtask

  // Directed: refusals, out-of-place commands, zero and short tx, every verdict.
  task automatic directed_items();
    put_item(rpf_pkg::CMD_TX_BYTE, 8'h00, 7'd0, 1'b0);       // payload byte while idle
    put_item(rpf_pkg::CMD_RX_BYTE, 8'hFF, 7'h7F, 1'b1);      // rx byte while idle
    put_item(rpf_pkg::CMD_RELEASE, 8'h00, 7'd0, 1'b0);       // nothing held
    put_item(CMD_RSVD_LO, 8'hFF, 7'h7F, 1'b1);
    put_item(CMD_RSVD_HI, 8'h00, 7'd0, 1'b0);
    put_item(rpf_pkg::CMD_TX_START, 8'h00, 7'd3, 1'b1);      // channel busy
    put_item(rpf_pkg::CMD_TX_START, 8'h00, 7'd65, 1'b0);     // just over max payload
    put_item(rpf_pkg::CMD_TX_START, 8'hFF, 7'h7F, 1'b0);
    put_item(rpf_pkg::CMD_TX_START, 8'h00, 7'd0, 1'b0);      // header + trailer at once
    put_item(rpf_pkg::CMD_TX_START, 8'h00, 7'd2, 1'b0);
    put_item(rpf_pkg::CMD_TX_START, 8'h00, 7'd1, 1'b0);      // refused: still sending
    put_item(rpf_pkg::CMD_LISTEN, 8'h00, 7'd0, 1'b0);        // refused: still sending
    put_item(rpf_pkg::CMD_TX_BYTE, 8'h00, 7'd0, 1'b0);
    put_item(rpf_pkg::CMD_TX_BYTE, 8'hFF, 7'h7F, 1'b1);      // last byte -> trailer
    put_item(rpf_pkg::CMD_LISTEN, 8'h00, 7'd0, 1'b0);
    put_item(rpf_pkg::CMD_LISTEN, 8'h00, 7'd0, 1'b0);        // refused: already listening
    put_item(rpf_pkg::CMD_TX_START, 8'h00, 7'd1, 1'b0);      // refused while receiving
    put_item(rpf_pkg::CMD_RELEASE, 8'h00, 7'd0, 1'b0);       // refused while receiving
    rx_frame(1, 4);                                          // CRC high corrupted
    rx_frame(1, -1);                                         // good -> held
    put_item(rpf_pkg::CMD_RX_BYTE, 8'h55, 7'd0, 1'b0);       // refused while held
    put_item(rpf_pkg::CMD_RELEASE, 8'h00, 7'd0, 1'b0);
    // oversized received length: status length bad, then reception restarts
    put_item(rpf_pkg::CMD_LISTEN, 8'h00, 7'd0, 1'b0);
    rx_byte(8'h01);
    rx_byte(8'd65);
    rx_flush();
    go_idle();
  endtask

  // Random transmit: mostly short payloads, some random-size, a few full-size or oversize.
  task automatic rand_tx();
    int r;
    int plen;
    r = $urandom_range(99);
    if (r < 80) begin
      plen = $urandom_range(6);
    end else if (r < 85) begin
      plen = PAYLOAD_MAX;
    end else if (r < 95) begin
      plen = $urandom_range(PAYLOAD_MAX);
    end else begin
      plen = $urandom_range(127, PAYLOAD_MAX + 1);
    end
    go_idle();
    if ($urandom_range(9) == 0) begin
      put_item(rpf_pkg::CMD_TX_START, 8'($urandom), 7'(plen), 1'b1);
    end
    put_item(rpf_pkg::CMD_TX_START, 8'($urandom), 7'(plen), 1'b0);
    while (sb.mode == rpf_pkg::MODE_SEND) begin
      put_item(rpf_pkg::CMD_TX_BYTE, 8'($urandom), 7'($urandom), 1'($urandom));
    end
  endtask

  // Random reception: good frames mostly, some corrupted, a few oversize
  // lengths that run to the length check or the buffer limit.
  task automatic rand_rx();
    int r;
    int len;
    r = $urandom_range(99);
    len = $urandom_range(5);
    go_idle();
    put_item(rpf_pkg::CMD_LISTEN, 8'($urandom), 7'($urandom), 1'($urandom));
    if (r < 65) begin
      rx_frame(len, -1);
    end else if (r < 93) begin
      rx_frame(len, $urandom_range(len + 3));
    end else begin
      rx_byte(8'($urandom));
      rx_byte(8'($urandom_range(255, PAYLOAD_MAX + 1)));
    end
    rx_flush();
    if (sb.mode == rpf_pkg::MODE_HELD && $urandom_range(9) < 7) begin
      put_item(rpf_pkg::CMD_RELEASE, 8'($urandom), 7'($urandom), 1'($urandom));
    end
  endtask

  task automatic random_phase();
    int r;
    phase_items = 0;
    while (phase_items < ITEMS_PER_PHASE) begin
      r = $urandom_range(99);
      if (r < 40) begin
        rand_tx();
      end else if (r < 75) begin
        rand_rx();
      end else begin
        repeat ($urandom_range(3, 1)) begin
          put_item(3'($urandom), 8'($urandom), 7'($urandom), 1'($urandom));
        end
      end
      // mid-phase hold-off until the output is fully drained
      if (phase_items >= ITEMS_PER_PHASE / 2 && phase_items < ITEMS_PER_PHASE / 2 + 12) begin
        wait_empty();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 0: directed, no idling
    set_regs(8'hFF, 8'h00);
    directed_items();

    // phase 1: no idling
    set_regs(8'h00, 8'hFF);
    random_phase();

    // phase 2: sender mostly idle
    set_regs(8'($urandom), 8'($urandom));
    send_idle_pct = 82;
    recv_stall_pct = 0;
    random_phase();

    // phase 3: receiver mostly stalled
    set_regs(8'hFF, 8'hFF);
    send_idle_pct = 0;
    recv_stall_pct = 82;
    random_phase();

    // phase 4: both sides idle now and then
    set_regs(8'($urandom), 8'($urandom));
    send_idle_pct = 31;
    recv_stall_pct = 31;
    random_phase();

    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
